// ----- sv/max_pool_2d_with_argmax_macros.svh -----
// assertion macros for the max pooling block
// no dependencies; included by the top level
`ifndef MAX_POOL_2D_WITH_ARGMAX_MACROS_SVH
`define MAX_POOL_2D_WITH_ARGMAX_MACROS_SVH
`ifndef SYNTHESIS
`define MP2A_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("mp2a assertion failed");
`define MP2A_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("mp2a assertion failed");
`else
`define MP2A_ASSERT_IMP(label, clk, rst_n, a, b)
`define MP2A_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- sv/mp2a_pkg.sv -----
// shared types and constants for the max pooling block
// no dependencies
package mp2a_pkg;

	localparam int DEF_MAX_WIDTH    = 64;
	localparam int DEF_MAX_HEIGHT   = 64;
	localparam int DEF_MAX_CHANNELS = 16;
	localparam int DEF_MAX_KERNEL   = 8;

	localparam logic [6:0] RST_WIDTH_IN    = 7'd64;
	localparam logic [6:0] RST_HEIGHT_IN   = 7'd64;
	localparam logic [4:0] RST_CHANNELS_IN = 5'd1;
	localparam logic [3:0] RST_KERNEL_SIZE = 4'd2;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		REG_WIDTH_IN    = 2'd0,
		REG_HEIGHT_IN   = 2'd1,
		REG_CHANNELS_IN = 2'd2,
		REG_KERNEL_SIZE = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		CMD_FORWARD  = 1'b0,
		CMD_BACKWARD = 1'b1
	} cmd_t;

	// one classified item between front and back
	typedef struct packed {
		cmd_t               cmd;
		logic signed [15:0] value;
		logic [15:0]        idx;        // input index, or output select for backward
		logic [15:0]        oidx;
		logic               first;
		logic               last;
		logic               frame_last;
	} item_t;

endpackage

// ----- sv/max_pool_2d_with_argmax.sv -----
// top level of the streaming max pooling block with argmax
// depends on mp2a_pkg, mp2a_front, mp2a_queue, mp2a_back and the macros header
//
// Input stream s_*: tuser is the command (0 forward sample, 1 backward
// error), tdata carries value and out_select. Forward samples arrive in
// raster order, channels interleaved. Output stream m_*: tuser is the kind,
// tlast marks the last pooled result of a frame, tdata carries position,
// result_value and winner_index.
// A forward sample that completes a window yields a pooled result; every
// backward item yields the routed error at the stored argmax input index.
// An item passes the queue, a registered memory read stage and the output
// register. Throughput is one item per cycle unless the receiver stalls; the
// running max line is read-modify-written with adjacent-item forwarding.
// A four-entry queue parts the front from the back; when the receiver
// stalls, the output register holds and the queue fills, then s_tready drops.
// Reset restores default config and restarts the frame; the argmax store is
// not cleared. cfg_we writes one register and restarts the frame position.
`include "max_pool_2d_with_argmax_macros.svh"
module max_pool_2d_with_argmax #(
	parameter int MAX_WIDTH    = mp2a_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = mp2a_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = mp2a_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_KERNEL   = mp2a_pkg::DEF_MAX_KERNEL
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value, out_select
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // position, result_value, winner_index
	output logic        m_tuser,   // kind
	output logic        m_tlast    // frame_end
);
	import mp2a_pkg::*;

	localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int LAW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int QW = $bits(item_t) + LAW;

	item_t f_item, q_item;
	logic [LAW-1:0] f_line, q_line;
	logic push, pop, q_full, q_empty;

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	// front: classify and track frame position
	mp2a_front #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
		.MAX_CHANNELS(MAX_CHANNELS), .MAX_KERNEL(MAX_KERNEL), .LAW(LAW)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .cmd(s_tuser), .value(s_tdata[15:0]),
		.out_select(s_tdata[31:16]), .item(f_item), .line(f_line)
	);

	// queue between front and back
	mp2a_queue #(.WIDTH(QW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata({f_line, f_item}),
		.pop(pop), .rdata({q_line, q_item}),
		.full(q_full), .empty(q_empty)
	);

	// back: memories and output register
	mp2a_back #(.LAW(LAW), .LINE_DEPTH(LINE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .q_item(q_item), .q_line(q_line), .pop(pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	// checks
	`MP2A_ASSERT_IMP(a_bwd_fields, clk, arst_n, m_tvalid && m_tuser, m_tdata[47:32] == 16'd0 && !m_tlast)
	`MP2A_ASSERT_NXT(a_push_fills, clk, arst_n, s_tvalid && s_tready, !q_empty)

endmodule

// ----- sv/mp2a_front.sv -----
// front end: config registers, frame position tracking, item classification
// depends on mp2a_pkg
module mp2a_front #(
	parameter int MAX_WIDTH    = mp2a_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = mp2a_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = mp2a_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_KERNEL   = mp2a_pkg::DEF_MAX_KERNEL,
	parameter int LAW          = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [6:0]            cfg_data,
	input  logic                  push,
	input  logic                  cmd,
	input  logic [15:0]           value,
	input  logic [15:0]           out_select,
	output mp2a_pkg::item_t       item,
	output logic [LAW-1:0]        line
);
	import mp2a_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int CHW = $clog2(MAX_CHANNELS + 1);
	localparam int KW = $clog2(MAX_KERNEL + 1);

	logic [6:0] width_q, height_q;
	logic [4:0] channels_q;
	logic [3:0] kernel_q;
	logic [WW-1:0] w_eff, col_q;
	logic [HW-1:0] h_eff, row_q;
	logic [CHW-1:0] c_eff, chan_q;
	logic [KW-1:0] k_eff, col_phase_q, row_phase_q;
	logic [LAW:0] ocolc_q;
	logic [15:0] obase_q, idx_q;
	logic chan_end, col_end, row_end, col_ph_end, row_ph_end;

	// clamp registers into their legal range
	always_comb begin
		if (width_q == 7'd0) w_eff = WW'(1);
		else if (int'(width_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(width_q);
		if (height_q == 7'd0) h_eff = HW'(1);
		else if (int'(height_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
		else h_eff = HW'(height_q);
		if (channels_q == 5'd0) c_eff = CHW'(1);
		else if (int'(channels_q) > MAX_CHANNELS) c_eff = CHW'(MAX_CHANNELS);
		else c_eff = CHW'(channels_q);
		if (kernel_q == 4'd0) k_eff = KW'(1);
		else if (int'(kernel_q) > MAX_KERNEL) k_eff = KW'(MAX_KERNEL);
		else k_eff = KW'(kernel_q);
	end

	// position flags
	assign chan_end   = (chan_q == c_eff - CHW'(1));
	assign col_end    = (col_q == w_eff - WW'(1));
	assign row_end    = (row_q == h_eff - HW'(1));
	assign col_ph_end = (col_phase_q == k_eff - KW'(1));
	assign row_ph_end = (row_phase_q == k_eff - KW'(1));

	// classify the incoming item
	always_comb begin
		item.cmd        = cmd_t'(cmd);
		item.value      = $signed(value);
		item.idx        = (cmd == CMD_BACKWARD) ? out_select : idx_q;
		item.oidx       = 16'(32'(obase_q) + 32'(ocolc_q) + 32'(chan_q));
		item.first      = (row_phase_q == '0) && (col_phase_q == '0);
		item.last       = (row_ph_end || row_end) && (col_ph_end || col_end);
		item.frame_last = row_end && col_end && chan_end;
		line            = LAW'(32'(ocolc_q) + 32'(chan_q));
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= RST_WIDTH_IN;
			height_q   <= RST_HEIGHT_IN;
			channels_q <= RST_CHANNELS_IN;
			kernel_q   <= RST_KERNEL_SIZE;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_WIDTH_IN:    width_q    <= cfg_data;
				REG_HEIGHT_IN:   height_q   <= cfg_data;
				REG_CHANNELS_IN: channels_q <= cfg_data[4:0];
				REG_KERNEL_SIZE: kernel_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// raster position counters, restarted by any config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0; row_q <= '0; chan_q <= '0;
			col_phase_q <= '0; row_phase_q <= '0;
			ocolc_q <= '0; obase_q <= '0; idx_q <= '0;
		end else if (cfg_we) begin
			col_q <= '0; row_q <= '0; chan_q <= '0;
			col_phase_q <= '0; row_phase_q <= '0;
			ocolc_q <= '0; obase_q <= '0; idx_q <= '0;
		end else if (push && cmd == CMD_FORWARD) begin
			idx_q <= idx_q + 16'd1;
			if (!chan_end) begin
				chan_q <= chan_q + CHW'(1);
			end else begin
				chan_q <= '0;
				if (!col_end) begin
					col_q <= col_q + WW'(1);
					if (col_ph_end) begin
						col_phase_q <= '0;
						ocolc_q     <= ocolc_q + (LAW+1)'(c_eff);
					end else begin
						col_phase_q <= col_phase_q + KW'(1);
					end
				end else begin
					col_q       <= '0;
					col_phase_q <= '0;
					ocolc_q     <= '0;
					if (row_end) begin
						row_q       <= '0;
						row_phase_q <= '0;
						obase_q     <= '0;
						idx_q       <= '0;
					end else begin
						row_q <= row_q + HW'(1);
						if (row_ph_end) begin
							row_phase_q <= '0;
							obase_q <= 16'(32'(obase_q) + 32'(ocolc_q) + 32'(c_eff));
						end else begin
							row_phase_q <= row_phase_q + KW'(1);
						end
					end
				end
			end
		end
	end

endmodule

// ----- sv/mp2a_queue.sv -----
// short fifo between front and back
// depends on mp2a_pkg for the depth
module mp2a_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	import mp2a_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW:0] count_q;
	logic do_push, do_pop;

	assign full    = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= wdata;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0; rptr_q <= '0; count_q <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + PW'(1);
			if (do_pop) rptr_q <= rptr_q + PW'(1);
			count_q <= count_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

endmodule

// ----- sv/mp2a_back.sv -----
// back end: running max line, argmax store, output register
// depends on mp2a_pkg
module mp2a_back #(
	parameter int LAW        = 10,
	parameter int LINE_DEPTH = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  mp2a_pkg::item_t q_item,
	input  logic [LAW-1:0]  q_line,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [47:0]     m_tdata,   // position, result_value, winner_index
	output logic            m_tuser,   // kind
	output logic            m_tlast    // frame_end
);
	import mp2a_pkg::*;

	logic [31:0] line_mem [LINE_DEPTH];
	logic [15:0] arg_mem [65536];

	logic advance, take;
	logic s2_valid_s2;
	item_t item_s2;
	logic [LAW-1:0] line_s2;
	logic [31:0] rd_line_s2;
	logic [15:0] rd_arg_s2;
	logic lfw_valid_q, afw_valid_q;
	logic [LAW-1:0] lfw_addr_q;
	logic [31:0] lfw_data_q;
	logic [15:0] afw_addr_q, afw_data_q;
	logic [31:0] cur, entry;
	logic [15:0] arg_val;
	logic upd, line_we, arg_we, has_res;

	assign advance = !m_tvalid || m_tready;
	assign pop     = advance;
	assign take    = advance && !q_empty;

	// merge memory data with the write from the previous stage
	always_comb begin
		cur     = (lfw_valid_q && lfw_addr_q == line_s2) ? lfw_data_q : rd_line_s2;
		arg_val = (afw_valid_q && afw_addr_q == item_s2.idx) ? afw_data_q : rd_arg_s2;
		upd     = item_s2.first || (item_s2.value >= $signed(cur[31:16]));
		entry   = upd ? {item_s2.value, item_s2.idx} : cur;
		line_we = advance && s2_valid_s2 && item_s2.cmd == CMD_FORWARD && upd;
		arg_we  = advance && s2_valid_s2 && item_s2.cmd == CMD_FORWARD && item_s2.last;
		has_res = (item_s2.cmd == CMD_BACKWARD) || item_s2.last;
	end

	// memories, registered reads
	always_ff @(posedge clk) begin
		if (line_we) line_mem[line_s2] <= entry;
		if (arg_we) arg_mem[item_s2.oidx] <= entry[15:0];
		if (take) begin
			rd_line_s2 <= line_mem[q_line];
			rd_arg_s2  <= arg_mem[q_item.idx];
			item_s2    <= q_item;
			line_s2    <= q_line;
		end
	end

	// forwarding payload
	always_ff @(posedge clk) begin
		if (line_we) begin
			lfw_addr_q <= line_s2;
			lfw_data_q <= entry;
		end
		if (arg_we) begin
			afw_addr_q <= item_s2.oidx;
			afw_data_q <= entry[15:0];
		end
	end

	// stage and forwarding valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
			lfw_valid_q <= 1'b0;
			afw_valid_q <= 1'b0;
			m_tvalid    <= 1'b0;
		end else begin
			if (advance) begin
				s2_valid_s2 <= !q_empty;
				m_tvalid    <= s2_valid_s2 && has_res;
			end
			if (line_we) lfw_valid_q <= 1'b1;
			if (arg_we) afw_valid_q <= 1'b1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance && s2_valid_s2 && has_res) begin
			if (item_s2.cmd == CMD_BACKWARD) begin
				m_tdata <= {16'd0, item_s2.value, arg_val};
				m_tuser <= CMD_BACKWARD;
				m_tlast <= 1'b0;
			end else begin
				m_tdata <= {entry[15:0], entry[31:16], item_s2.oidx};
				m_tuser <= CMD_FORWARD;
				m_tlast <= item_s2.frame_last;
			end
		end
	end

endmodule
